/* rtl/bounded_array_list_engine_unit_assert.svh */
// Assertion macros used by the list engine top level.
`ifndef BOUNDED_ARRAY_LIST_ENGINE_UNIT_ASSERT_SVH
`define BOUNDED_ARRAY_LIST_ENGINE_UNIT_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define BAL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define BAL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/bal_pkg.sv */
// Shared types, operation codes and status codes of the list engine.
package bal_pkg;
    localparam int unsigned ListDepth = 16;
    localparam int unsigned ModeW     = 4;
    localparam int unsigned ValueW    = 32;
    localparam int unsigned StatusW   = 3;
    localparam int unsigned CountW    = 5;

    localparam logic [ModeW-1:0] MODE_INS_FRONT  = 4'd0;
    localparam logic [ModeW-1:0] MODE_APPEND     = 4'd1;
    localparam logic [ModeW-1:0] MODE_INS_SORTED = 4'd2;
    localparam logic [ModeW-1:0] MODE_RM_FIRST   = 4'd3;
    localparam logic [ModeW-1:0] MODE_RM_LAST    = 4'd4;
    localparam logic [ModeW-1:0] MODE_RM_VALUE   = 4'd5;
    localparam logic [ModeW-1:0] MODE_SORT       = 4'd6;
    localparam logic [ModeW-1:0] MODE_REVERSE    = 4'd7;
    localparam logic [ModeW-1:0] MODE_CLEAR      = 4'd8;
    localparam logic [ModeW-1:0] MODE_DUMP       = 4'd9;

    localparam logic [StatusW-1:0] ST_OK        = 3'd0;
    localparam logic [StatusW-1:0] ST_FULL      = 3'd1;
    localparam logic [StatusW-1:0] ST_DUP       = 3'd2;
    localparam logic [StatusW-1:0] ST_EMPTY     = 3'd3;
    localparam logic [StatusW-1:0] ST_NOT_FOUND = 3'd4;
    localparam logic [StatusW-1:0] ST_SORTED    = 3'd5;

    localparam logic [ValueW-1:0] VACANT = '1;

    typedef struct packed {
        logic [ModeW-1:0]  mode;
        logic [ValueW-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic [StatusW-1:0] status;
        logic [ValueW-1:0]  element;
        logic [CountW-1:0]  count;
        logic               is_empty;
        logic               is_sorted;
        logic               last;
    } t_out_word;

    // Result of the shared compare unit.
    typedef struct packed {
        logic eq;
        logic lt;
    } t_cmp;
endpackage

/* rtl/bal_if.sv */
// Valid/ready channel interfaces for input and result words.
interface bal_in_if;
    logic              valid;
    logic              ready;
    bal_pkg::t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bal_out_if;
    logic               valid;
    logic               ready;
    bal_pkg::t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/bal_cmp.sv */
// Shared signed compare unit used by every scan of the sequencer.
module bal_cmp (
    input  logic [bal_pkg::ValueW-1:0] i_a,
    input  logic [bal_pkg::ValueW-1:0] i_b,
    output bal_pkg::t_cmp              o_cmp
);
    assign o_cmp.eq = (i_a == i_b);
    assign o_cmp.lt = ($signed(i_a) < $signed(i_b));
endmodule

/* rtl/bounded_array_list_engine_unit.sv */
// Top level of the bounded array list engine: sequencer, slot file and outputs.
// The list holds up to LIST_DEPTH signed words in slots kept in flip-flops, and
// one sequencer walks them a slot per cycle, unless a dump waits on a full
// output register, through a single shared signed compare unit. Each item is
// decoded, then its slots are visited: inserts, removals and scans walk up to
// LIST_DEPTH slots, reverse swaps pairs from both ends, a dump gives one result
// word per entry, and sort runs bubble-sort passes that shrink and stop once a
// pass makes no swap. Clear resets every slot together. After each insert,
// removal, sort or reverse a sortedness pass over the live slots refreshes the
// sorted flag reported in every result word. The input is not ready while an
// item is in work; a result word waits in the output register until taken.
module bounded_array_list_engine_unit #(
    parameter int unsigned LIST_DEPTH = bal_pkg::ListDepth
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    bal_in_if.sink  i_in,
    bal_out_if.source o_out
);
    `include "bounded_array_list_engine_unit_assert.svh"

    localparam int unsigned IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    // Counters and walk indexes must hold LIST_DEPTH + 1.
    localparam int unsigned CW = $clog2(LIST_DEPTH + 2);
    localparam int unsigned VW = bal_pkg::ValueW;
    localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

    // Sequencer states.
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DEC    = 4'd1;
    localparam logic [3:0] S_FIND   = 4'd2;  // search for insert/remove position
    localparam logic [3:0] S_SHUP   = 4'd3;  // shift up toward r_pos
    localparam logic [3:0] S_SHDN   = 4'd4;  // shift down from r_i
    localparam logic [3:0] S_SORT   = 4'd5;  // one compare-swap per cycle
    localparam logic [3:0] S_REV    = 4'd6;
    localparam logic [3:0] S_CLR    = 4'd7;
    localparam logic [3:0] S_CHK    = 4'd8;  // sortedness pass
    localparam logic [3:0] S_EMIT   = 4'd9;
    localparam logic [3:0] S_DUMP   = 4'd10;
    localparam logic [3:0] S_WAIT   = 4'd11;

    logic [VW-1:0] r_slot [LIST_DEPTH];
    logic [CW-1:0] r_count, n_count;
    logic [3:0]    r_state, n_state;
    logic [bal_pkg::ModeW-1:0] r_mode, n_mode;
    logic [VW-1:0] r_value, n_value;
    logic [CW-1:0] r_i, n_i;       // walk index
    logic [CW-1:0] r_j, n_j;       // second index (shift end, pass bound)
    logic [CW-1:0] r_pos, n_pos;
    logic          r_swp, n_swp;
    logic          r_sorted, n_sorted;
    logic [bal_pkg::StatusW-1:0] r_st, n_st;
    logic          r_ovalid, n_ovalid;
    bal_pkg::t_out_word r_odata, n_odata;

    // Slot write port: up to two writes a cycle (swap).
    logic          wa_en, wb_en;
    logic [IW-1:0] wa_idx, wb_idx;
    logic [VW-1:0] wa_dat, wb_dat;
    logic          clr_all;

    // Shared compare unit operands.
    logic [VW-1:0] cmp_a, cmp_b;
    bal_pkg::t_cmp cmp;
    bal_cmp u_cmp (.i_a(cmp_a), .i_b(cmp_b), .o_cmp(cmp));

    function automatic logic [IW-1:0] ix(input logic [CW-1:0] v);
        ix = IW'(v);
    endfunction

    logic [CW-1:0] i1;
    assign i1 = r_i + CW'(1);

    always_comb begin
        n_state  = r_state;
        n_mode   = r_mode;
        n_value  = r_value;
        n_i      = r_i;
        n_j      = r_j;
        n_pos    = r_pos;
        n_swp    = r_swp;
        n_sorted = r_sorted;
        n_st     = r_st;
        n_count  = r_count;
        n_ovalid = r_ovalid;
        n_odata  = r_odata;
        wa_en = 1'b0; wb_en = 1'b0;
        wa_idx = '0; wb_idx = '0;
        wa_dat = '0; wb_dat = '0;
        clr_all = 1'b0;
        cmp_a = r_value;
        cmp_b = r_slot[ix(r_i)];

        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_mode  = i_in.data.mode;
                    n_value = i_in.data.value;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_st = bal_pkg::ST_OK;
                n_i  = '0;
                n_state = S_EMIT;
                priority if (r_mode == bal_pkg::MODE_INS_FRONT
                             || r_mode == bal_pkg::MODE_APPEND
                             || r_mode == bal_pkg::MODE_INS_SORTED) begin
                    if (r_count >= DEPTH_C) begin
                        n_st = bal_pkg::ST_FULL;
                    end else if (r_mode == bal_pkg::MODE_INS_SORTED) begin
                        n_state = S_FIND;
                    end else begin
                        n_pos   = (r_mode == bal_pkg::MODE_INS_FRONT) ? '0 : r_count;
                        n_j     = r_count;
                        n_state = S_SHUP;
                    end
                end else if (r_mode == bal_pkg::MODE_RM_FIRST
                             || r_mode == bal_pkg::MODE_RM_LAST
                             || r_mode == bal_pkg::MODE_RM_VALUE
                             || r_mode == bal_pkg::MODE_SORT
                             || r_mode == bal_pkg::MODE_REVERSE
                             || r_mode == bal_pkg::MODE_DUMP) begin
                    if (r_count == '0) begin
                        n_st = bal_pkg::ST_EMPTY;
                    end else if (r_mode == bal_pkg::MODE_RM_FIRST) begin
                        n_i = '0; n_state = S_SHDN;
                    end else if (r_mode == bal_pkg::MODE_RM_LAST) begin
                        n_i = r_count - CW'(1); n_state = S_SHDN;
                    end else if (r_mode == bal_pkg::MODE_RM_VALUE) begin
                        n_state = S_FIND;
                    end else if (r_mode == bal_pkg::MODE_SORT) begin
                        if (r_sorted) begin
                            n_st = bal_pkg::ST_SORTED;
                        end else begin
                            n_j = r_count - CW'(1); n_swp = 1'b0; n_state = S_SORT;
                        end
                    end else if (r_mode == bal_pkg::MODE_REVERSE) begin
                        n_j = r_count - CW'(1); n_state = S_REV;
                    end else begin
                        n_state = S_DUMP;
                    end
                end else if (r_mode == bal_pkg::MODE_CLEAR) begin
                    n_state = S_CLR;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_FIND: begin
                if (r_i >= r_count) begin
                    if (r_mode == bal_pkg::MODE_RM_VALUE) begin
                        n_st = bal_pkg::ST_NOT_FOUND; n_state = S_EMIT;
                    end else begin
                        n_pos = r_i; n_j = r_count; n_state = S_SHUP;
                    end
                end else if (cmp.eq) begin
                    if (r_mode == bal_pkg::MODE_RM_VALUE) begin
                        n_state = S_SHDN;
                    end else begin
                        n_st = bal_pkg::ST_DUP; n_state = S_EMIT;
                    end
                end else if (cmp.lt && r_mode == bal_pkg::MODE_INS_SORTED) begin
                    n_pos = r_i; n_j = r_count; n_state = S_SHUP;
                end else begin
                    n_i = i1;
                end
            end
            S_SHUP: begin
                if (r_j > r_pos) begin
                    wa_en = 1'b1; wa_idx = ix(r_j);
                    wa_dat = r_slot[ix(r_j - CW'(1))];
                    n_j = r_j - CW'(1);
                end else begin
                    wa_en = 1'b1; wa_idx = ix(r_pos); wa_dat = r_value;
                    n_count = r_count + CW'(1);
                    n_i = '0; n_sorted = 1'b1; n_state = S_CHK;
                end
            end
            S_SHDN: begin
                if (i1 < r_count) begin
                    wa_en = 1'b1; wa_idx = ix(r_i); wa_dat = r_slot[ix(i1)];
                    n_i = i1;
                end else begin
                    wa_en = 1'b1; wa_idx = ix(r_i); wa_dat = bal_pkg::VACANT;
                    n_count = r_count - CW'(1);
                    n_i = '0; n_sorted = 1'b1; n_state = S_CHK;
                end
            end
            S_SORT: begin
                // r_j is the bound of the current pass; compare slots i and i+1.
                if (r_i < r_j) begin
                    cmp_a = r_slot[ix(i1)];
                    cmp_b = r_slot[ix(r_i)];
                    if (cmp.lt) begin
                        wa_en = 1'b1; wa_idx = ix(r_i);  wa_dat = r_slot[ix(i1)];
                        wb_en = 1'b1; wb_idx = ix(i1);   wb_dat = r_slot[ix(r_i)];
                        n_swp = 1'b1;
                    end
                    n_i = i1;
                end else if (!r_swp || r_j <= CW'(1)) begin
                    n_i = '0; n_sorted = 1'b1; n_state = S_CHK;
                end else begin
                    n_j = r_j - CW'(1); n_i = '0; n_swp = 1'b0;
                end
            end
            S_REV: begin
                if (r_i < r_j) begin
                    wa_en = 1'b1; wa_idx = ix(r_i); wa_dat = r_slot[ix(r_j)];
                    wb_en = 1'b1; wb_idx = ix(r_j); wb_dat = r_slot[ix(r_i)];
                    n_i = i1; n_j = r_j - CW'(1);
                end else begin
                    n_i = '0; n_sorted = 1'b1; n_state = S_CHK;
                end
            end
            S_CLR: begin
                clr_all = 1'b1;
                n_count = '0; n_sorted = 1'b1; n_state = S_EMIT;
            end
            S_CHK: begin
                if (i1 < r_count) begin
                    cmp_a = r_slot[ix(i1)];
                    cmp_b = r_slot[ix(r_i)];
                    if (cmp.lt) begin
                        n_sorted = 1'b0;
                    end
                    n_i = i1;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid = 1'b1;
                    n_odata.status    = r_st;
                    n_odata.element   = '0;
                    n_odata.count     = bal_pkg::CountW'(r_count);
                    n_odata.is_empty  = (r_count == '0);
                    n_odata.is_sorted = r_sorted;
                    n_odata.last      = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_DUMP: begin
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid = 1'b1;
                    n_odata.status    = bal_pkg::ST_OK;
                    n_odata.element   = r_slot[ix(r_i)];
                    n_odata.count     = bal_pkg::CountW'(r_count);
                    n_odata.is_empty  = 1'b0;
                    n_odata.is_sorted = r_sorted;
                    n_odata.last      = (i1 == r_count);
                    n_i = i1;
                    if (i1 == r_count) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_odata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_sorted <= 1'b1;
            r_i      <= '0;
            r_j      <= '0;
            r_swp    <= 1'b0;
            r_st     <= bal_pkg::ST_OK;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
            r_sorted <= n_sorted;
            r_i      <= n_i;
            r_j      <= n_j;
            r_swp    <= n_swp;
            r_st     <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode  <= n_mode;
        r_value <= n_value;
        r_pos   <= n_pos;
        r_odata <= n_odata;
    end

    // Every slot resets to the vacant value together with the control state.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < LIST_DEPTH; k++) begin
            if (!i_rst_n || clr_all) begin
                r_slot[k] <= bal_pkg::VACANT;
            end else if (wa_en && wa_idx == IW'(k)) begin
                r_slot[k] <= wa_dat;
            end else if (wb_en && wb_idx == IW'(k)) begin
                r_slot[k] <= wb_dat;
            end
        end
    end

    `BAL_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= DEPTH_C, "count over depth")
    `BAL_ASSERT_IMP(a_busy_not_ready, i_clk, i_rst_n, r_state != S_IDLE, !i_in.ready, "ready while busy")
    `BAL_ASSERT_NEXT(a_hold_out, i_clk, i_rst_n, o_out.valid && !o_out.ready, o_out.valid && $stable(o_out.data), "result dropped")
    `BAL_ASSERT_IMP(a_empty_flag, i_clk, i_rst_n, o_out.valid, o_out.data.is_empty == (o_out.data.count == '0), "empty flag mismatch")
endmodule

/* tb/tb_bounded_array_list_engine_unit.sv */
// Self-checking testbench of the bounded array list engine with a built-in list predictor.
module tb_bounded_array_list_engine_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DEPTH = bal_pkg::ListDepth;
    localparam int unsigned MW = bal_pkg::ModeW;
    localparam int unsigned VW = bal_pkg::ValueW;
    localparam int unsigned SW = bal_pkg::StatusW;
    // The run may take at most this many cycles before it is called hung.
    localparam int unsigned CYCLE_LIMIT = 600000;
    // Selector codes 10 to 15 name no operation.
    localparam logic [MW-1:0] MODE_UNUSED_FIRST = 4'd10;
    localparam logic [MW-1:0] MODE_UNUSED_LAST  = 4'd15;

    logic i_clk;
    logic i_rst_n;

    bal_in_if  in_ch ();
    bal_out_if out_ch ();

    bounded_array_list_engine_unit #(.LIST_DEPTH(DEPTH)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    // Predicted list contents and the queue of result words still owed.
    logic signed [VW-1:0]     list_slots [DEPTH];
    int unsigned              list_len;
    bal_pkg::t_out_word       owed_words [$];

    int unsigned error_count;
    bit          quiet_sender;     // When set, the sender never inserts gaps.
    bit          quiet_receiver;   // When set, the receiver never stalls at random.
    int unsigned stall_left;       // Cycles the receiver still holds off.

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The sorted flag is a signed non-decreasing test over the live slots.
    function automatic bit list_in_order();
        for (int unsigned k = 0; k + 1 < list_len; k++) begin
            if (list_slots[k + 1] < list_slots[k]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void owe_word(logic [SW-1:0] st, logic [VW-1:0] elem,
                                     bit is_last);
        bal_pkg::t_out_word w;
        w.status    = st;
        w.element   = elem;
        w.count     = list_len[bal_pkg::CountW-1:0];
        w.is_empty  = (list_len == 0);
        w.is_sorted = list_in_order();
        w.last      = is_last;
        owed_words.push_back(w);
    endfunction

    function automatic void place_at(int unsigned pos, logic signed [VW-1:0] v);
        for (int unsigned j = list_len; j > pos; j--) list_slots[j] = list_slots[j - 1];
        list_slots[pos] = v;
        list_len++;
    endfunction

    function automatic void take_out(int unsigned pos);
        for (int unsigned j = pos; j + 1 < list_len; j++) list_slots[j] = list_slots[j + 1];
        list_slots[list_len - 1] = bal_pkg::VACANT;
        list_len--;
    endfunction

    // Applies one accepted word to the predicted list and queues its results.
    function automatic void predict_list_op(bal_pkg::t_in_word w);
        logic [SW-1:0]        st;
        logic signed [VW-1:0] v;
        logic signed [VW-1:0] tmp;
        int unsigned          pos;
        bit                   swapped;
        st = bal_pkg::ST_OK;
        v  = w.value;
        case (w.mode)
            bal_pkg::MODE_INS_FRONT, bal_pkg::MODE_APPEND: begin
                if (list_len >= DEPTH) st = bal_pkg::ST_FULL;
                else place_at(w.mode == bal_pkg::MODE_INS_FRONT ? 0 : list_len, v);
            end
            bal_pkg::MODE_INS_SORTED: begin
                if (list_len >= DEPTH) begin
                    st = bal_pkg::ST_FULL;
                end else begin
                    // Scan stops at the first greater entry; an equal one before it
                    // rejects the word.
                    for (pos = 0; pos < list_len; pos++) begin
                        if (list_slots[pos] == v) begin
                            st = bal_pkg::ST_DUP;
                            break;
                        end
                        if (v < list_slots[pos]) break;
                    end
                    if (st == bal_pkg::ST_OK) place_at(pos, v);
                end
            end
            bal_pkg::MODE_RM_FIRST, bal_pkg::MODE_RM_LAST: begin
                if (list_len == 0) st = bal_pkg::ST_EMPTY;
                else take_out(w.mode == bal_pkg::MODE_RM_FIRST ? 0 : list_len - 1);
            end
            bal_pkg::MODE_RM_VALUE: begin
                if (list_len == 0) begin
                    st = bal_pkg::ST_EMPTY;
                end else begin
                    st = bal_pkg::ST_NOT_FOUND;
                    for (pos = 0; pos < list_len; pos++) begin
                        if (list_slots[pos] == v) begin
                            take_out(pos);
                            st = bal_pkg::ST_OK;
                            break;
                        end
                    end
                end
            end
            bal_pkg::MODE_SORT: begin
                if (list_len == 0) st = bal_pkg::ST_EMPTY;
                else if (list_in_order()) st = bal_pkg::ST_SORTED;
                else begin
                    for (int unsigned p = 0; p + 1 < list_len; p++) begin
                        swapped = 1'b0;
                        for (int unsigned j = 0; j + 1 < list_len - p; j++) begin
                            if (list_slots[j + 1] < list_slots[j]) begin
                                tmp = list_slots[j];
                                list_slots[j] = list_slots[j + 1];
                                list_slots[j + 1] = tmp;
                                swapped = 1'b1;
                            end
                        end
                        if (!swapped) break;
                    end
                end
            end
            bal_pkg::MODE_REVERSE: begin
                if (list_len == 0) st = bal_pkg::ST_EMPTY;
                else begin
                    for (int unsigned k = 0; k < list_len / 2; k++) begin
                        tmp = list_slots[k];
                        list_slots[k] = list_slots[list_len - 1 - k];
                        list_slots[list_len - 1 - k] = tmp;
                    end
                end
            end
            bal_pkg::MODE_CLEAR: begin
                for (int unsigned k = 0; k < DEPTH; k++) list_slots[k] = bal_pkg::VACANT;
                list_len = 0;
            end
            bal_pkg::MODE_DUMP: begin
                if (list_len == 0) st = bal_pkg::ST_EMPTY;
                else begin
                    // A dump of a populated list owes one word per entry.
                    for (int unsigned k = 0; k < list_len; k++)
                        owe_word(bal_pkg::ST_OK, list_slots[k], k + 1 == list_len);
                    return;
                end
            end
            default: ;
        endcase
        owe_word(st, '0, 1'b1);
    endfunction

    // Sends one word. Valid stays high from one word to the next unless a gap is
    // inserted, so it never gets two assignments in one time step.
    task automatic send_word(logic [MW-1:0] mode, logic [VW-1:0] value);
        bal_pkg::t_in_word w;
        w.mode  = mode;
        w.value = value;
        if (!quiet_sender && $urandom_range(99) < 31) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_list_op(w);
    endtask

    task automatic stop_sending();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_until_drained();
        while (owed_words.size() != 0) @(posedge i_clk);
    endtask

    // Result checker and receiver stall control share one process.
    initial begin
        bal_pkg::t_out_word want;
        bal_pkg::t_out_word got;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                got = out_ch.data;
                if (owed_words.size() == 0) begin
                    $display("%0t: unexpected word status=%0d element=%0d", $realtime,
                             got.status, $signed(got.element));
                    error_count++;
                end else begin
                    want = owed_words.pop_front();
                    if (got.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d", $realtime,
                                 want.status, got.status);
                        error_count++;
                    end
                    if (got.element !== want.element) begin
                        $display("%0t: element expected %0d actual %0d", $realtime,
                                 $signed(want.element), $signed(got.element));
                        error_count++;
                    end
                    if (got.count !== want.count) begin
                        $display("%0t: count expected %0d actual %0d", $realtime,
                                 want.count, got.count);
                        error_count++;
                    end
                    if (got.is_empty !== want.is_empty) begin
                        $display("%0t: is_empty expected %0b actual %0b", $realtime,
                                 want.is_empty, got.is_empty);
                        error_count++;
                    end
                    if (got.is_sorted !== want.is_sorted) begin
                        $display("%0t: is_sorted expected %0b actual %0b", $realtime,
                                 want.is_sorted, got.is_sorted);
                        error_count++;
                    end
                    if (got.last !== want.last) begin
                        $display("%0t: last expected %0b actual %0b", $realtime,
                                 want.last, got.last);
                        error_count++;
                    end
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= quiet_receiver || ($urandom_range(99) >= 31);
            end
        end
    end

    // Watchdog on the cycle count.
    initial begin
        int unsigned cycles;
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("bounded_array_list_engine_unit verification failed");
                $finish;
            end
        end
    end

    // Picks a value: half the time from a small pool, so duplicates and matches occur.
    function automatic logic [VW-1:0] pick_value();
        case ($urandom_range(3))
            0:       return $urandom();
            1:       return {$urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF};
            default: return $signed($urandom_range(12)) - 6;
        endcase
    endfunction

    // Empty-list answers for every removal, sort, reverse and dump mode and the unused selectors.
    task automatic test_empty_list();
        send_word(bal_pkg::MODE_RM_FIRST, '0);
        send_word(bal_pkg::MODE_RM_LAST, '0);
        send_word(bal_pkg::MODE_RM_VALUE, 32'd5);
        send_word(bal_pkg::MODE_SORT, '0);
        send_word(bal_pkg::MODE_REVERSE, '0);
        send_word(bal_pkg::MODE_DUMP, '0);
        for (int m = MODE_UNUSED_FIRST; m <= MODE_UNUSED_LAST; m++)
            send_word(m[MW-1:0], $urandom());
    endtask

    // Value extremes, duplicates, not-found, sort, reverse, fill to full, clear.
    task automatic test_list_edges();
        send_word(bal_pkg::MODE_APPEND, 32'h7FFF_FFFF);
        send_word(bal_pkg::MODE_INS_FRONT, 32'h8000_0000);
        send_word(bal_pkg::MODE_INS_SORTED, 32'd0);
        send_word(bal_pkg::MODE_INS_SORTED, 32'd0);
        send_word(bal_pkg::MODE_RM_VALUE, 32'd77);
        send_word(bal_pkg::MODE_SORT, '0);
        send_word(bal_pkg::MODE_REVERSE, '0);
        send_word(bal_pkg::MODE_SORT, '0);
        send_word(bal_pkg::MODE_INS_SORTED, 32'hFFFF_FFFF);
        while (list_len < DEPTH) send_word(bal_pkg::MODE_APPEND, $urandom());
        send_word(bal_pkg::MODE_INS_FRONT, 32'd1);
        send_word(bal_pkg::MODE_APPEND, 32'd1);
        send_word(bal_pkg::MODE_INS_SORTED, 32'd1);
        send_word(bal_pkg::MODE_DUMP, '0);
        send_word(bal_pkg::MODE_SORT, '0);
        send_word(bal_pkg::MODE_CLEAR, '0);
    endtask

    // Mostly list building and editing with random content, plus some noise.
    task automatic test_random_ops(int unsigned n_items);
        logic [MW-1:0] mode;
        int unsigned   r;
        for (int unsigned k = 0; k < n_items; k++) begin
            r = $urandom_range(99);
            if (r < 18) mode = bal_pkg::MODE_INS_SORTED;
            else if (r < 30) mode = bal_pkg::MODE_APPEND;
            else if (r < 40) mode = bal_pkg::MODE_INS_FRONT;
            else if (r < 48) mode = bal_pkg::MODE_RM_FIRST;
            else if (r < 55) mode = bal_pkg::MODE_RM_LAST;
            else if (r < 65) mode = bal_pkg::MODE_RM_VALUE;
            else if (r < 74) mode = bal_pkg::MODE_SORT;
            else if (r < 81) mode = bal_pkg::MODE_REVERSE;
            else if (r < 91) mode = bal_pkg::MODE_DUMP;
            else if (r < 95) mode = bal_pkg::MODE_CLEAR;
            else mode = MW'($urandom_range(MODE_UNUSED_LAST, MODE_UNUSED_FIRST));
            // Removing a value that is actually present is the common case.
            if (mode == bal_pkg::MODE_RM_VALUE && list_len != 0 && $urandom_range(1))
                send_word(mode, list_slots[$urandom_range(list_len - 1)]);
            else
                send_word(mode, pick_value());
        end
    endtask

    // The receiver holds off long enough that the input stalls behind it.
    task automatic test_receiver_hold();
        stall_left = 400;
        test_random_ops(20);
    endtask

    // Back-to-back words with no gaps on either side.
    task automatic test_full_rate();
        quiet_sender   = 1'b1;
        quiet_receiver = 1'b1;
        test_random_ops(60);
        quiet_sender   = 1'b0;
        quiet_receiver = 1'b0;
    endtask

    // The sender pauses until every owed word has arrived.
    task automatic test_sender_pause();
        stop_sending();
        wait_until_drained();
        test_random_ops(20);
    endtask

    initial begin
        error_count    = 0;
        quiet_sender   = 1'b0;
        quiet_receiver = 1'b0;
        stall_left     = 0;
        list_len       = 0;
        for (int unsigned k = 0; k < DEPTH; k++) list_slots[k] = bal_pkg::VACANT;
        i_rst_n        <= 1'b0;
        in_ch.valid    <= 1'b0;
        in_ch.data     <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_list();
        test_list_edges();
        test_random_ops(130);
        test_receiver_hold();
        test_full_rate();
        test_sender_pause();
        test_random_ops(110);

        stop_sending();
        wait_until_drained();
        repeat (DEPTH * DEPTH) @(posedge i_clk);
        if (error_count == 0 && owed_words.size() == 0) begin
            $display("bounded_array_list_engine_unit verification clean");
        end else begin
            $display("bounded_array_list_engine_unit verification failed");
        end
        $finish;
    end
endmodule

/* filelist.f */
+incdir+rtl
rtl/bal_pkg.sv
rtl/bal_if.sv
rtl/bal_cmp.sv
rtl/bounded_array_list_engine_unit.sv
tb/tb_bounded_array_list_engine_unit.sv
